/* rtl/core/wildcard_byte_pattern_scan_core_macros.svh */
// Assertion helpers for the byte pattern scan core.
`ifndef WILDCARD_BYTE_PATTERN_SCAN_CORE_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_CORE_MACROS_SVH

// Check a consequence in the same cycle as its trigger.
`define WBPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define WBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/wbps_pkg.sv */
package wbps_pkg;

    // Wildcard signature byte: matches any data byte
    localparam logic [7:0] WILDCARD_BYTE = 8'hCC;

    // Signature storage and length register
    localparam int PAT_REG_BYTES = 16;
    localparam int PAT_LEN_W     = 5;
    localparam int PAT_IDX_W     = 4;

    // Result offset field width
    localparam int OFFSET_W = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

    // Per-cell control from the top level
    typedef struct packed {
        logic       shift;
        logic       active;
        logic [7:0] expected;
    } cell_ctrl_t;

endpackage

/* rtl/core/wbps_cell.sv */
module wbps_cell (
    input  logic                clk,
    input  wbps_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]          shift_in,
    output logic [7:0]          shift_out,
    output logic                hit
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       care;

    // Advance the window byte on each accepted request
    assign byte_next = ctrl.shift ? shift_in : byte_reg;

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign shift_out = byte_reg;

    // Compare the byte entering this position against its signature byte
    assign care = ctrl.active && (ctrl.expected != wbps_pkg::WILDCARD_BYTE);
    assign hit  = !care || (shift_in == ctrl.expected);

endmodule

/* rtl/core/wildcard_byte_pattern_scan_core.sv */
// Output: a result is registered into the output register in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; the window compare runs in parallel across the cell row,
// and the output register accepts a new byte whenever it is empty or being drained.
// Reset: clears the byte counter, the match flag, the output valid and the signature
// registers (length reads as one); window bytes are not cleared.
`include "wildcard_byte_pattern_scan_core_macros.svh"

module wildcard_byte_pattern_scan_core #(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic [7:0]                         data_byte,
    input  logic                               last_byte,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic                               found,
    output logic [wbps_pkg::OFFSET_W-1:0]      match_offset
);

    localparam int LIMIT = (MAX_PATTERN < wbps_pkg::PAT_REG_BYTES) ?
                           MAX_PATTERN : wbps_pkg::PAT_REG_BYTES;
    localparam int POS_W = ($clog2(MAX_PATTERN + 1) > wbps_pkg::PAT_LEN_W) ?
                           $clog2(MAX_PATTERN + 1) : wbps_pkg::PAT_LEN_W;

    // Signature registers
    logic [wbps_pkg::CFG_DATA_W-1:0] pat_low_reg;
    logic [wbps_pkg::CFG_DATA_W-1:0] pat_high_reg;
    logic [wbps_pkg::PAT_LEN_W-1:0]  pat_len_reg;
    logic [wbps_pkg::PAT_LEN_W-1:0]  eff_len;
    logic [wbps_pkg::PAT_REG_BYTES*8-1:0] pat_bytes;

    // Scan state
    logic [OFFSET_BITS-1:0] count_reg;
    logic [OFFSET_BITS-1:0] count_next;
    logic [OFFSET_BITS-1:0] off_full;
    logic                   match_seen_reg;
    logic                   match_seen_next;

    // Output register
    logic                          result_valid_reg;
    logic                          result_valid_next;
    logic                          found_reg;
    logic [wbps_pkg::OFFSET_W-1:0] offset_reg;

    logic item_fire;
    logic cfg_fire;
    logic len_ok;
    logic window_hit;
    logic match_now;
    logic result_gen;

    logic [7:0]             link [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] hits;

    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign item_ready = !result_valid_reg || result_ready;
    assign item_fire  = item_valid && item_ready;

    // Write signature registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= wbps_pkg::PAT_LEN_W'(1);
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                wbps_pkg::CFG_PATTERN_LOW:    pat_low_reg  <= cfg_data;
                wbps_pkg::CFG_PATTERN_HIGH:   pat_high_reg <= cfg_data;
                wbps_pkg::CFG_PATTERN_LENGTH: pat_len_reg  <= cfg_data[wbps_pkg::PAT_LEN_W-1:0];
                default:                      ;
            endcase
        end
    end

    // Clamp the length into one..LIMIT
    always_comb
    begin
        if (pat_len_reg == '0)
            eff_len = wbps_pkg::PAT_LEN_W'(1);
        else if (pat_len_reg > wbps_pkg::PAT_LEN_W'(LIMIT))
            eff_len = wbps_pkg::PAT_LEN_W'(LIMIT);
        else
            eff_len = pat_len_reg;
    end

    assign pat_bytes = {pat_high_reg, pat_low_reg};

    // Row of window cells; position zero holds the newest byte
    assign link[0] = data_byte;

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++)
        begin : g_cell
            wbps_pkg::cell_ctrl_t      ctrl;
            logic [wbps_pkg::PAT_IDX_W-1:0] pat_idx;

            assign pat_idx = wbps_pkg::PAT_IDX_W'(POS_W'(eff_len) - POS_W'(k + 1));

            assign ctrl.shift    = item_fire;
            assign ctrl.active   = POS_W'(eff_len) > POS_W'(k);
            assign ctrl.expected = pat_bytes[pat_idx*8 +: 8];

            wbps_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .shift_in  (link[k]),
                .shift_out (link[k+1]),
                .hit       (hits[k])
            );
        end
    endgenerate

    assign window_hit = &hits;

    // Saturating byte count and match decision
    assign count_next = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    assign len_ok     = count_next >= OFFSET_BITS'(eff_len);
    assign off_full   = count_next - OFFSET_BITS'(eff_len);
    assign match_now  = !match_seen_reg && len_ok && window_hit;
    assign result_gen = match_now || (last_byte && !match_seen_reg);

    assign match_seen_next = match_seen_reg || match_now;

    // Advance scan state; drop it at the region end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            match_seen_reg <= 1'b0;
        end
        else if (item_fire)
        begin
            if (last_byte)
            begin
                count_reg      <= '0;
                match_seen_reg <= 1'b0;
            end
            else
            begin
                count_reg      <= count_next;
                match_seen_reg <= match_seen_next;
            end
        end
    end

    // Hold the result until taken
    always_comb
    begin
        if (item_fire)
            result_valid_next = result_gen;
        else if (result_ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_fire && result_gen)
        begin
            found_reg  <= match_now;
            offset_reg <= match_now ? wbps_pkg::OFFSET_W'(off_full) : '0;
        end
    end

    assign result_valid = result_valid_reg;
    assign found        = found_reg;
    assign match_offset = offset_reg;

    // Region end clears the scan state
    `WBPS_ASSERT_NEXT(a_region_clear, clk, rst_n, item_fire && last_byte,
        count_reg == '0 && !match_seen_reg, "scan state not cleared at region end")

    // No result once a match has been reported in this region
    `WBPS_ASSERT_NEXT(a_quiet_after_match, clk, rst_n, item_fire && match_seen_reg,
        !result_valid_reg, "result produced after match already reported")

    // A found result always comes with the match flag set or a region end
    `WBPS_ASSERT_NEXT(a_found_sets_flag, clk, rst_n, item_fire && match_now && !last_byte,
        match_seen_reg && result_valid_reg && found_reg, "match not recorded")

endmodule

/* dv/wildcard_byte_pattern_scan_core_tb.sv */
`timescale 1ns / 1ps

module wildcard_byte_pattern_scan_core_tb;

    localparam int WINDOW_DEPTH  = 16;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BYTES   = 62;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 200000;

    // Index with no register behind it; writes to it are dropped
    localparam logic [wbps_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum int {REGION_EMBED, REGION_NOISE, REGION_SHORT} region_kind_t;

    typedef struct packed {
        logic [7:0] value;
        logic       tail;
    } scan_byte_t;

    typedef struct packed {
        logic                          hit;
        logic [wbps_pkg::OFFSET_W-1:0] offset;
    } scan_report_t;

    logic                            clk;
    logic                            rst_n = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            item_valid = 1'b0;
    logic                            item_ready;
    logic [7:0]                      data_byte = '0;
    logic                            last_byte = 1'b0;
    logic                            result_valid;
    logic                            result_ready = 1'b0;
    logic                            found;
    logic [wbps_pkg::OFFSET_W-1:0]   match_offset;

    // Bytes waiting to be offered, and reports the block still owes
    scan_byte_t   byte_feed[$];
    scan_report_t pending_reports[$];
    scan_byte_t   offered;
    scan_report_t oldest;

    // Shadow of the signature registers
    logic [wbps_pkg::CFG_DATA_W-1:0] sig_low = '0;
    logic [wbps_pkg::CFG_DATA_W-1:0] sig_high = '0;
    logic [wbps_pkg::PAT_LEN_W-1:0]  sig_len = 5'd1;

    // Shadow of the scan state
    logic [7:0]                    recent_bytes [WINDOW_DEPTH];
    logic [wbps_pkg::OFFSET_W-1:0] region_count = '0;
    logic                          region_matched = 1'b0;

    int feed_idle_pct  = 35;
    int drain_idle_pct = 35;
    bit hold_armed     = 1'b0;
    bit hold_used      = 1'b0;
    int hold_left      = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    wildcard_byte_pattern_scan_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .found        (found),
        .match_offset (match_offset)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic note_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    function automatic logic [7:0] sig_byte(input int pos);
        if (pos < 8)
            return sig_low[8*pos +: 8];
        return sig_high[8*(pos-8) +: 8];
    endfunction

    // Zero acts as one, anything past the window acts as a full window
    function automatic int active_length();
        int span;
        span = int'(sig_len);
        if (span == 0)
            span = 1;
        if (span > WINDOW_DEPTH)
            span = WINDOW_DEPTH;
        return span;
    endfunction

    function automatic bit window_fits(input int span);
        logic [7:0] want;
        for (int i = 0; i < span; i++)
        begin
            want = sig_byte(i);
            if (want != wbps_pkg::WILDCARD_BYTE && want != recent_bytes[span-1-i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Shift one byte into the shadow window and queue whatever report it causes
    function automatic void advance_scan(input scan_byte_t item);
        int           span;
        scan_report_t rep;
        span = active_length();
        for (int i = WINDOW_DEPTH - 1; i > 0; i--)
            recent_bytes[i] = recent_bytes[i-1];
        recent_bytes[0] = item.value;
        if (region_count != '1)
            region_count++;
        if (!region_matched && region_count >= wbps_pkg::OFFSET_W'(span) && window_fits(span))
        begin
            region_matched = 1'b1;
            rep.hit    = 1'b1;
            rep.offset = region_count - wbps_pkg::OFFSET_W'(span);
            pending_reports.push_back(rep);
        end
        if (item.tail)
        begin
            if (!region_matched)
            begin
                rep.hit    = 1'b0;
                rep.offset = '0;
                pending_reports.push_back(rep);
            end
            for (int i = 0; i < WINDOW_DEPTH; i++)
                recent_bytes[i] = '0;
            region_count   = '0;
            region_matched = 1'b0;
        end
    endfunction

    // Byte driver: offer the next queued byte, predict on acceptance
    always @(posedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else
        begin
            if (item_valid && item_ready)
                advance_scan(offered);
            if (!item_valid || item_ready)
            begin
                if (byte_feed.size() != 0 && $urandom_range(99) >= feed_idle_pct)
                begin
                    offered = byte_feed.pop_front();
                    item_valid <= 1'b1;
                    data_byte  <= offered.value;
                    last_byte  <= offered.tail;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Result side ready: random stalls, plus one long hold-off when armed
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (hold_armed && !hold_used)
        begin
            hold_used    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= drain_idle_pct);
    end

    // Result monitor: compare each accepted result against the oldest pending report
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_reports.size() == 0)
                note_mismatch($sformatf("unexpected result found=%0b offset=%0d",
                                        found, match_offset));
            else
            begin
                oldest = pending_reports.pop_front();
                if (found !== oldest.hit)
                    note_mismatch($sformatf("found %0b, want %0b", found, oldest.hit));
                if (match_offset !== oldest.offset)
                    note_mismatch($sformatf("match_offset %0d, want %0d",
                                            match_offset, oldest.offset));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("wildcard_byte_pattern_scan_core_tb NOT OK");
            $finish;
        end
    end

    task automatic write_reg(input logic [wbps_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [wbps_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            wbps_pkg::CFG_PATTERN_LOW:    sig_low = val;
            wbps_pkg::CFG_PATTERN_HIGH:   sig_high = val;
            wbps_pkg::CFG_PATTERN_LENGTH: sig_len = val[wbps_pkg::PAT_LEN_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_signature(input logic [wbps_pkg::CFG_DATA_W-1:0] low,
                                 input logic [wbps_pkg::CFG_DATA_W-1:0] high,
                                 input logic [wbps_pkg::PAT_LEN_W-1:0] len_code);
        logic [wbps_pkg::CFG_DATA_W-1:0] len_word;
        len_word = {$urandom, $urandom};
        len_word[wbps_pkg::PAT_LEN_W-1:0] = len_code;
        write_reg(wbps_pkg::CFG_PATTERN_LOW, low);
        write_reg(wbps_pkg::CFG_PATTERN_HIGH, high);
        write_reg(wbps_pkg::CFG_PATTERN_LENGTH, len_word);
    endtask

    // Wait until no byte is queued or offered and no report is owed; sample
    // between edges so the driver's updates at the edge are settled
    task automatic wait_drained();
        do
            @(negedge clk);
        while (byte_feed.size() != 0 || item_valid || pending_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void push_byte(input logic [7:0] value, input logic tail);
        scan_byte_t item;
        item.value = value;
        item.tail  = tail;
        byte_feed.push_back(item);
    endfunction

    // Half the filler is drawn from the signature itself to provoke near misses
    function automatic logic [7:0] filler_byte(input int span);
        if ($urandom_range(1))
            return 8'($urandom);
        return sig_byte($urandom_range(span - 1));
    endfunction

    function automatic logic [7:0] random_sig_byte();
        if ($urandom_range(3) == 0)
            return wbps_pkg::WILDCARD_BYTE;
        return 8'($urandom);
    endfunction

    // Queue one region of the given kind; return its byte count
    function automatic int queue_region(input region_kind_t kind, input int span);
        int         size;
        int         at;
        logic [7:0] want;
        case (kind)
            REGION_EMBED:
            begin
                size = span + $urandom_range(12);
                at   = $urandom_range(size - span);
                for (int i = 0; i < size; i++)
                begin
                    if (i >= at && i < at + span)
                    begin
                        want = sig_byte(i - at);
                        if (want == wbps_pkg::WILDCARD_BYTE)
                            want = 8'($urandom);
                    end
                    else
                        want = filler_byte(span);
                    push_byte(want, i == size - 1);
                end
            end
            REGION_SHORT:
            begin
                size = (span > 1) ? $urandom_range(1, span - 1) : 1;
                for (int i = 0; i < size; i++)
                    push_byte(filler_byte(span), i == size - 1);
            end
            default:
            begin
                size = $urandom_range(1, 24);
                for (int i = 0; i < size; i++)
                    push_byte(filler_byte(span), i == size - 1);
            end
        endcase
        return size;
    endfunction

    initial
    begin
        int                              queued;
        int                              pick;
        logic [wbps_pkg::PAT_LEN_W-1:0]  len_code;
        logic [wbps_pkg::CFG_DATA_W-1:0] low;
        logic [wbps_pkg::CFG_DATA_W-1:0] high;
        region_kind_t                    kind;

        for (int i = 0; i < WINDOW_DEPTH; i++)
            recent_bytes[i] = '0;

        // Hold reset, then release it
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset signature: single zero byte
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'h5A, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_drained();

        // Length zero with a wildcard signature: match on a one-byte region
        write_reg(CFG_SPARE, {$urandom, $urandom});
        set_signature({56'h0, wbps_pkg::WILDCARD_BYTE}, '0, 5'd0);
        push_byte(8'hAB, 1'b1);
        wait_drained();

        // Oversized length, all wildcards: short region then full-window match on last byte
        set_signature({8{wbps_pkg::WILDCARD_BYTE}}, {8{wbps_pkg::WILDCARD_BYTE}}, 5'd20);
        push_byte(8'h01, 1'b0);
        push_byte(8'h80, 1'b1);
        for (int i = 0; i < WINDOW_DEPTH; i++)
            push_byte(8'($urandom), i == WINDOW_DEPTH - 1);
        wait_drained();

        // Random phases over a spread of signature settings
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: len_code = 5'd1;
                1: len_code = 5'd16;
                2: len_code = 5'd0;
                3: len_code = 5'd31;
                4: len_code = 5'($urandom_range(17, 30));
                default: len_code = 5'($urandom_range(1, 16));
            endcase
            if (p == 5)
            begin
                low  = '1;
                high = '1;
            end
            else
            begin
                for (int b = 0; b < 8; b++)
                begin
                    low[8*b +: 8]  = random_sig_byte();
                    high[8*b +: 8] = random_sig_byte();
                end
            end
            set_signature(low, high, len_code);

            feed_idle_pct  = (p == 3) ? 0 : 35;
            drain_idle_pct = (p == 3) ? 0 : 35;

            queued = 0;
            while (queued < PHASE_BYTES)
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                    kind = REGION_EMBED;
                else if (pick < 85)
                    kind = REGION_NOISE;
                else
                    kind = REGION_SHORT;
                queued += queue_region(kind, active_length());
            end

            // Stall the result side long enough to back the block up
            if (p == 6)
                hold_armed = 1'b1;
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("wildcard_byte_pattern_scan_core_tb OK");
        else
            $display("wildcard_byte_pattern_scan_core_tb NOT OK");
        $finish;
    end

endmodule
